// File: sv/ps2_set1_scancode_to_ascii_unit_macros.svh
// Assertion macros shared by the checkers.
`ifndef PS2_SET1_SCANCODE_TO_ASCII_UNIT_MACROS_SVH
`define PS2_SET1_SCANCODE_TO_ASCII_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, off during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Holds at every edge, reset included.
`define CHK_ALWAYS(label, clk, cond) \
    label: assert property (@(posedge clk) (cond)) \
        else $error("invariant check failed");

`endif

// File: sv/ps2s1_pkg.sv
package ps2s1_pkg;

    localparam logic [7:0] PREFIX_BYTE   = 8'he0;
    localparam logic [6:0] CTRL_MAKE     = 7'h1d;
    localparam logic [6:0] LSHIFT_MAKE   = 7'h2a;
    localparam logic [6:0] RSHIFT_MAKE   = 7'h36;
    localparam logic [6:0] ALT_MAKE      = 7'h38;
    localparam logic [6:0] CAPS_MAKE     = 7'h3a;
    localparam logic [6:0] ROM_END       = 7'h3b;
    localparam logic [6:0] BACKTICK_MAKE = 7'h29;
    localparam logic [6:0] CHAR_A_LOWER  = 7'h61;
    localparam logic [6:0] CHAR_L_LOWER  = 7'h6c;
    localparam logic [6:0] CHAR_U_LOWER  = 7'h75;

    localparam logic [1:0] STATUS_NONE    = 2'd0;
    localparam logic [1:0] STATUS_CHAR    = 2'd1;
    localparam logic [1:0] STATUS_DROP    = 2'd2;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [7:0] scan_byte;
        logic       buffer_full;
    } scan_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] char_code;
    } result_t;

    typedef struct packed {
        logic prefix_seen;
        logic ctrl_held;
        logic shift_held;
        logic alt_held;
        logic caps_lock_on;
    } mods_t;

    // Key ROM: {unshifted, shifted}
    function automatic logic [13:0] key_rom(input logic [5:0] idx);
        logic [13:0] e;
        case (idx)
            6'h01: e = {7'h1b, 7'h1b};
            6'h02: e = {7'h31, 7'h21};
            6'h03: e = {7'h32, 7'h40};
            6'h04: e = {7'h33, 7'h23};
            6'h05: e = {7'h34, 7'h24};
            6'h06: e = {7'h35, 7'h25};
            6'h07: e = {7'h36, 7'h5e};
            6'h08: e = {7'h37, 7'h26};
            6'h09: e = {7'h38, 7'h2a};
            6'h0a: e = {7'h39, 7'h28};
            6'h0b: e = {7'h30, 7'h29};
            6'h0c: e = {7'h2d, 7'h5f};
            6'h0d: e = {7'h3d, 7'h2b};
            6'h0e: e = {7'h08, 7'h08};
            6'h0f: e = {7'h09, 7'h09};
            6'h10: e = {7'h71, 7'h51};
            6'h11: e = {7'h77, 7'h57};
            6'h12: e = {7'h65, 7'h45};
            6'h13: e = {7'h72, 7'h52};
            6'h14: e = {7'h74, 7'h54};
            6'h15: e = {7'h79, 7'h59};
            6'h16: e = {7'h75, 7'h55};
            6'h17: e = {7'h69, 7'h49};
            6'h18: e = {7'h6f, 7'h4f};
            6'h19: e = {7'h70, 7'h50};
            6'h1a: e = {7'h5b, 7'h7b};
            6'h1b: e = {7'h5d, 7'h7d};
            6'h1c: e = {7'h0d, 7'h0d};
            6'h1e: e = {7'h61, 7'h41};
            6'h1f: e = {7'h73, 7'h53};
            6'h20: e = {7'h64, 7'h44};
            6'h21: e = {7'h66, 7'h46};
            6'h22: e = {7'h67, 7'h47};
            6'h23: e = {7'h68, 7'h48};
            6'h24: e = {7'h6a, 7'h4a};
            6'h25: e = {7'h6b, 7'h4b};
            6'h26: e = {7'h6c, 7'h4c};
            6'h27: e = {7'h3b, 7'h3a};
            6'h28: e = {7'h27, 7'h22};
            6'h29: e = {7'h60, 7'h7e};
            6'h2b: e = {7'h5c, 7'h7c};
            6'h2c: e = {7'h7a, 7'h5a};
            6'h2d: e = {7'h78, 7'h58};
            6'h2e: e = {7'h63, 7'h43};
            6'h2f: e = {7'h76, 7'h56};
            6'h30: e = {7'h62, 7'h42};
            6'h31: e = {7'h6e, 7'h4e};
            6'h32: e = {7'h6d, 7'h4d};
            6'h33: e = {7'h2c, 7'h3c};
            6'h34: e = {7'h2e, 7'h3e};
            6'h35: e = {7'h2f, 7'h3f};
            6'h37: e = {7'h2a, 7'h2a};
            6'h39: e = {7'h20, 7'h20};
            default: e = 14'h0000;
        endcase
        return e;
    endfunction

endpackage

// File: sv/ps2s1_decode.sv
module ps2s1_decode (
    input  ps2s1_pkg::scan_t   item,
    input  ps2s1_pkg::mods_t   mods,
    output ps2s1_pkg::result_t result,
    output ps2s1_pkg::mods_t   mods_next
);

    logic        ext;
    logic        brk;
    logic [6:0]  code;
    logic        known;
    logic        symbol;
    logic        col;
    logic [13:0] entry;
    logic [6:0]  ch;

    assign ext  = mods.prefix_seen;
    assign brk  = item.scan_byte[7];
    assign code = item.scan_byte[6:0];

    always_comb
    begin
        known = (!ext && (code != 7'h00) && (code < ps2s1_pkg::ROM_END)) ||
                (ext && (code inside {ps2s1_pkg::CTRL_MAKE, ps2s1_pkg::ALT_MAKE}));
        symbol = !ext && ((code < 7'h0e) ||
                 (code inside {ps2s1_pkg::BACKTICK_MAKE, 7'h1a, 7'h1b, 7'h2b, 7'h27,
                               7'h28, 7'h33, 7'h34, 7'h35}));
        col   = symbol ? mods.shift_held : (mods.shift_held ^ mods.caps_lock_on);
        entry = ps2s1_pkg::key_rom(code[5:0]);
        ch    = col ? entry[6:0] : entry[13:7];
        if (mods.ctrl_held &&
            ((ch == ps2s1_pkg::CHAR_L_LOWER) || (ch == ps2s1_pkg::CHAR_U_LOWER)))
        begin
            ch = ch - ps2s1_pkg::CHAR_A_LOWER;
        end
    end

    always_comb
    begin
        mods_next        = mods;
        result.status    = ps2s1_pkg::STATUS_NONE;
        result.char_code = 7'h00;
        if (item.scan_byte == ps2s1_pkg::PREFIX_BYTE)
        begin
            mods_next.prefix_seen = 1'b1;
        end
        else
        begin
            mods_next.prefix_seen = 1'b0;
            if (brk)
            begin
                if (code == ps2s1_pkg::CTRL_MAKE)
                    mods_next.ctrl_held = 1'b0;
                else if (!ext && (code inside {ps2s1_pkg::LSHIFT_MAKE, ps2s1_pkg::RSHIFT_MAKE}))
                    mods_next.shift_held = 1'b0;
                else if (code == ps2s1_pkg::ALT_MAKE)
                    mods_next.alt_held = 1'b0;
            end
            else if (known)
            begin
                if (ch != 7'h00)
                begin
                    if (item.buffer_full)
                    begin
                        result.status = ps2s1_pkg::STATUS_DROP;
                    end
                    else
                    begin
                        result.status    = ps2s1_pkg::STATUS_CHAR;
                        result.char_code = ch;
                    end
                end
                else if (code == ps2s1_pkg::CTRL_MAKE)
                    mods_next.ctrl_held = 1'b1;
                else if (!ext && (code inside {ps2s1_pkg::LSHIFT_MAKE, ps2s1_pkg::RSHIFT_MAKE}))
                    mods_next.shift_held = 1'b1;
                else if (code == ps2s1_pkg::ALT_MAKE)
                    mods_next.alt_held = 1'b1;
                else if (!ext && (code == ps2s1_pkg::CAPS_MAKE))
                    mods_next.caps_lock_on = !mods.caps_lock_on;
            end
            else
            begin
                result.status = ps2s1_pkg::STATUS_UNKNOWN;
            end
        end
    end

endmodule

// File: sv/ps2_set1_scancode_to_ascii_unit.sv
// Scan-code set 1 to ASCII translator.
// Input channel scan/scan_valid/scan_ready carries one keyboard byte per item
// together with the downstream buffer-full flag. Output channel
// result/result_valid/result_ready returns exactly one item per input item:
// a status code and, for an emitted character, its ASCII code.
// An accepted item waits in the input register and passes through the decode into
// the result register when that register is free or being read; throughput is one
// item per cycle while result_ready is high; decode and key ROM are combinational.
// Modifier and prefix state is updated as each item moves into the result
// register, so consecutive bytes see the state left by the byte before.
// Reset clears the prefix flag, held modifiers and caps lock, and empties
// both registers.
// When result_ready is low the result holds; the input register keeps
// accepting until it is also occupied, then scan_ready drops.
module ps2_set1_scancode_to_ascii_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                scan_valid,
    output logic                scan_ready,
    input  ps2s1_pkg::scan_t    scan,
    output logic                result_valid,
    input  logic                result_ready,
    output ps2s1_pkg::result_t  result
);

    logic                item_valid_reg;
    ps2s1_pkg::scan_t    item_reg;
    logic                result_valid_reg;
    ps2s1_pkg::result_t  result_reg;
    ps2s1_pkg::mods_t    mods_reg;

    ps2s1_pkg::result_t  result_next;
    ps2s1_pkg::mods_t    mods_next;
    logic                item_valid_next;
    logic                result_valid_next;
    logic                advance;

    ps2s1_decode u_decode (
        .item      (item_reg),
        .mods      (mods_reg),
        .result    (result_next),
        .mods_next (mods_next)
    );

    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign scan_ready = !item_valid_reg || advance;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (scan_valid && scan_ready)
            item_valid_next = 1'b1;
        else if (advance)
            item_valid_next = 1'b0;

        result_valid_next = result_valid_reg;
        if (advance)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            mods_reg         <= '0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
            if (advance)
                mods_reg <= mods_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_valid && scan_ready)
            item_reg <= scan;
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: sv/ps2s1_checker.sv
`include "ps2_set1_scancode_to_ascii_unit_macros.svh"

module ps2s1_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                scan_valid,
    input  logic                scan_ready,
    input  ps2s1_pkg::scan_t    scan,
    input  logic                result_valid,
    input  logic                result_ready,
    input  ps2s1_pkg::result_t  result
);

    logic stalled;
    logic is_char;
    logic scan_waiting;

    assign stalled      = result_valid && !result_ready;
    assign is_char      = result.status == ps2s1_pkg::STATUS_CHAR;
    assign scan_waiting = scan_valid && !scan_ready;

    `CHK_NEXT(a_result_holds, clk, rst_n, stalled, result_valid && $stable(result))
    `CHK_NEXT(a_scan_holds, clk, rst_n, scan_waiting, scan_valid && $stable(scan))
    `CHK_IMPLY(a_char_nonzero, clk, rst_n, result_valid && is_char, result.char_code != 7'h00)
    `CHK_IMPLY(a_code_zero, clk, rst_n, result_valid && !is_char, result.char_code == 7'h00)
    `CHK_ALWAYS(a_reset_empty, clk, rst_n || !result_valid)

endmodule

bind ps2_set1_scancode_to_ascii_unit ps2s1_checker u_checker (.*);
